FILE: design/tgarle_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgarle_pkg - shared types and constants of the tga rle pixel decoder
// register indexes, error codes and the configuration bundle
// ---------------------------------------------------------------------------
package tgarle_pkg;

   localparam int PIXEL_COUNT_BITS_DEF = 24;
   localparam int TOTAL_BITS           = 25;
   localparam int CSR_ADDR_BITS        = 4;
   localparam int CSR_DATA_BITS        = 32;
   localparam int BPP_BITS             = 3;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_COMPRESSED_MODE = 2'd0,
      REG_PIXEL_STRIDE    = 2'd1,
      REG_TOTAL_PIXELS    = 2'd2,
      REG_UNUSED          = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_OVERRUN  = 2'd1,
      ERR_EARLY_END = 2'd2
   } err_type;

   localparam logic [7:0] COUNT_MASK = 8'h7f;

   typedef struct packed {
      logic                  compressed_mode;
      logic [BPP_BITS-1:0]   pixel_stride;
      logic [TOTAL_BITS-1:0] total_pixels;
   } cfg_type;

endpackage

FILE: design/tgarle_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tgarle_csr - configuration registers
// apb-style write and read of compressed_mode, pixel stride, total_pixels
// ---------------------------------------------------------------------------
module tgarle_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tgarle_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tgarle_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tgarle_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                 csr_pready,
   output tgarle_pkg::cfg_type                  cfg
);

   tgarle_pkg::cfg_type       cfg_ff, cfg_in;
   tgarle_pkg::reg_index_type index;
   logic                      wr_en;

   assign index      = tgarle_pkg::reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            tgarle_pkg::REG_COMPRESSED_MODE: cfg_in.compressed_mode = csr_pwdata[0];
            tgarle_pkg::REG_PIXEL_STRIDE:
               cfg_in.pixel_stride = csr_pwdata[tgarle_pkg::BPP_BITS-1:0];
            tgarle_pkg::REG_TOTAL_PIXELS:
               cfg_in.total_pixels = csr_pwdata[tgarle_pkg::TOTAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         tgarle_pkg::REG_COMPRESSED_MODE:
            csr_prdata = tgarle_pkg::CSR_DATA_BITS'(cfg_ff.compressed_mode);
         tgarle_pkg::REG_PIXEL_STRIDE:
            csr_prdata = tgarle_pkg::CSR_DATA_BITS'(cfg_ff.pixel_stride);
         tgarle_pkg::REG_TOTAL_PIXELS:
            csr_prdata = tgarle_pkg::CSR_DATA_BITS'(cfg_ff.total_pixels);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.compressed_mode <= 1'b1;
         cfg_ff.pixel_stride    <= 3'd4;
         cfg_ff.total_pixels    <= 25'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// a pixel result is registered and shows on rsp in the cycle after its last byte transfer
// throughput: one byte per cycle while rsp drains; each byte updates the packet/pixel state
// a new byte is taken while a finished result waits, as long as rsp drains
// reset (synchronous, active high) clears the decoder to "expect header",
// no pixels done, and sets compressed_mode 1, pixel stride 4, total_pixels 1
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder - tga pixel data stream decoder
// takes the pixel byte stream, handles raw and run packets and emits
// complete pixels with a repeat count, or an error item
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
   parameter int PIXEL_COUNT_BITS = tgarle_pkg::PIXEL_COUNT_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] data_byte
   input  logic [0:0]                           req_tuser,  // [0] stream_end
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha, [39:32] repeat_count
   output logic [39:0]                          rsp_tdata,
   output logic                                 rsp_tlast,  // image_last
   output logic [1:0]                           rsp_tuser,  // [1:0] error_code
   // configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tgarle_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tgarle_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tgarle_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                 csr_pready
);

   localparam int TB = tgarle_pkg::TOTAL_BITS;
   // clamp of the image size: no clamp needed once the limit passes the register range
   localparam int LIMIT_EXP = (PIXEL_COUNT_BITS >= TB) ? TB : PIXEL_COUNT_BITS;
   localparam logic [TB:0] TOTAL_LIMIT = (TB+1)'(1) << LIMIT_EXP;

   tgarle_pkg::cfg_type cfg;

   tgarle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // decoder state
   logic          awaiting_header_ff, awaiting_header_in;
   logic          packet_is_run_ff,   packet_is_run_in;
   logic [7:0]    pixels_left_ff,     pixels_left_in;
   logic [7:0]    run_length_ff,      run_length_in;
   logic [1:0]    byte_pos_ff,        byte_pos_in;
   logic [23:0]   assembly_ff,        assembly_in;
   logic [TB-1:0] pixels_done_ff,     pixels_done_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [39:0]         rsp_data_ff,  rsp_data_in;
   logic                rsp_last_ff,  rsp_last_in;
   tgarle_pkg::err_type rsp_err_ff,   rsp_err_in;

   logic          accept;
   logic          produce;
   logic [7:0]    data_byte;
   logic          stream_end;
   logic          bpp4;
   logic [TB:0]   total_eff;
   logic          idle;
   logic [7:0]    count;
   logic [TB:0]   header_sum;
   logic          need_byte;
   logic [7:0]    rep;
   logic [7:0]    blue, green, red, alpha;
   logic [TB-1:0] done_sum;
   logic          last;
   logic          restart;

   assign data_byte  = req_tdata;
   assign stream_end = req_tuser[0];

   // result slot free or being emptied this cycle
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   // stride 4 for any register value of 4 or more, else 3
   assign bpp4 = cfg.pixel_stride[2];

   always_comb begin
      total_eff = {1'b0, cfg.total_pixels};
      if (cfg.total_pixels == '0) begin
         total_eff = (TB+1)'(1);
      end
      if (total_eff > TOTAL_LIMIT) begin
         total_eff = TOTAL_LIMIT;
      end
   end

   assign idle = (pixels_done_ff == '0) && (byte_pos_ff == 2'd0) &&
                 (~cfg.compressed_mode || awaiting_header_ff);

   assign count      = {1'b0, data_byte[6:0] & tgarle_pkg::COUNT_MASK[6:0]} + 8'd1;
   assign header_sum = {1'b0, pixels_done_ff} + (TB+1)'(count);

   // partial pixel: more bytes still to come for this pixel
   assign need_byte = bpp4 ? (byte_pos_ff != 2'd3) : (byte_pos_ff < 2'd2);

   assign blue  = assembly_ff[7:0];
   assign green = assembly_ff[15:8];
   assign red   = bpp4 ? assembly_ff[23:16] : data_byte;
   assign alpha = bpp4 ? data_byte : 8'd0;

   always_comb begin
      rep = 8'd1;
      if (cfg.compressed_mode && packet_is_run_ff && (run_length_ff != 8'd0)) begin
         rep = run_length_ff;
      end
   end

   assign done_sum = pixels_done_ff + TB'(rep);
   assign last     = {1'b0, done_sum} >= total_eff;

   // next state and result of one byte transfer
   always_comb begin
      awaiting_header_in = awaiting_header_ff;
      packet_is_run_in   = packet_is_run_ff;
      pixels_left_in     = pixels_left_ff;
      run_length_in      = run_length_ff;
      byte_pos_in        = byte_pos_ff;
      assembly_in        = assembly_ff;
      pixels_done_in     = pixels_done_ff;
      produce            = 1'b0;
      restart            = 1'b0;
      rsp_data_in        = '0;
      rsp_last_in        = 1'b0;
      rsp_err_in         = tgarle_pkg::ERR_NONE;

      if (stream_end) begin
         // end between images is dropped silently
         if (!idle) begin
            restart    = 1'b1;
            produce    = 1'b1;
            rsp_err_in = tgarle_pkg::ERR_EARLY_END;
         end
      end else if (cfg.compressed_mode && awaiting_header_ff) begin
         if (header_sum > total_eff) begin
            restart    = 1'b1;
            produce    = 1'b1;
            rsp_err_in = tgarle_pkg::ERR_OVERRUN;
         end else begin
            awaiting_header_in = 1'b0;
            packet_is_run_in   = data_byte[7];
            pixels_left_in     = count;
            run_length_in      = count;
            byte_pos_in        = 2'd0;
            assembly_in        = '0;
         end
      end else if (need_byte) begin
         case (byte_pos_ff)
            2'd0:    assembly_in[7:0]   = data_byte;
            2'd1:    assembly_in[15:8]  = data_byte;
            2'd2:    assembly_in[23:16] = data_byte;
            default: ;
         endcase
         byte_pos_in = byte_pos_ff + 2'd1;
      end else begin
         // pixel complete
         byte_pos_in = 2'd0;
         assembly_in = '0;
         if (cfg.compressed_mode) begin
            pixels_left_in = (rep >= pixels_left_ff) ? 8'd0 : pixels_left_ff - rep;
            if (pixels_left_in == 8'd0) begin
               awaiting_header_in = 1'b1;
            end
         end
         pixels_done_in = done_sum;
         restart        = last;
         produce        = 1'b1;
         rsp_data_in    = {rep, alpha, red, green, blue};
         rsp_last_in    = last;
      end

      if (restart) begin
         awaiting_header_in = 1'b1;
         packet_is_run_in   = 1'b0;
         pixels_left_in     = 8'd0;
         run_length_in      = 8'd0;
         byte_pos_in        = 2'd0;
         assembly_in        = '0;
         pixels_done_in     = '0;
      end
   end

   // result slot: loaded on a byte transfer, emptied when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = produce;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_header_ff <= 1'b1;
         packet_is_run_ff   <= 1'b0;
         pixels_left_ff     <= 8'd0;
         run_length_ff      <= 8'd0;
         byte_pos_ff        <= 2'd0;
         assembly_ff        <= '0;
         pixels_done_ff     <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept) begin
            awaiting_header_ff <= awaiting_header_in;
            packet_is_run_ff   <= packet_is_run_in;
            pixels_left_ff     <= pixels_left_in;
            run_length_ff      <= run_length_in;
            byte_pos_ff        <= byte_pos_in;
            assembly_ff        <= assembly_in;
            pixels_done_ff     <= pixels_done_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the result slot, no reset needed
   always_ff @(posedge clock) begin
      if (accept && produce) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef ASSERT_OFF
   // input side must stall while an untaken result sits in the slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("byte taken while result slot is full");

   // error items carry no pixel count and never close an image
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff != tgarle_pkg::ERR_NONE) |->
      (rsp_data_ff[39:32] == 8'd0 && !rsp_last_ff))
      else $error("error item with pixel content");

   // pixel items repeat between 1 and 128 times
   a_rep_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff == tgarle_pkg::ERR_NONE) |->
      (rsp_data_ff[39:32] != 8'd0 && rsp_data_ff[39:32] <= 8'd128))
      else $error("repeat count out of range");

   // an error or a finished image restarts the decoder
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && produce && (rsp_err_in != tgarle_pkg::ERR_NONE || rsp_last_in)) |=>
      (awaiting_header_ff && pixels_done_ff == '0 && byte_pos_ff == 2'd0))
      else $error("decoder not restarted after image end or error");
`endif

endmodule

FILE: test/tb_tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder - self-checking bench of the tga rle pixel decoder
// feeds directed and random pixel streams in raw and rle mode, predicts every
// pixel and error transfer and compares it field by field on the rsp stream
// ---------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          RANDOM_BYTES = 530;   // directed part plus about 500

   // one rsp transfer, as the decoder should emit it
   typedef struct packed {
      logic [7:0]          blue;
      logic [7:0]          green;
      logic [7:0]          red;
      logic [7:0]          alpha;
      logic [7:0]          repeat_count;
      logic                image_last;
      tgarle_pkg::err_type error_code;
   } pixel_item_type;

   // ------------------------------------------------------------------------
   // predictor and scoreboard: mirrors the decoder state and the registers,
   // queues the transfers that each accepted byte must cause
   // ------------------------------------------------------------------------
   class tga_pixel_predictor;
      logic           compressed;
      logic [2:0]     stride_reg;
      logic [24:0]    total_reg;
      logic           awaiting_header;
      logic           packet_is_run;
      logic [7:0]     packet_left;
      logic [7:0]     run_len;
      logic [1:0]     byte_pos;
      logic [23:0]    assembly;
      logic [24:0]    done_count;
      pixel_item_type pending_pixels[$];
      int             mismatch_count;

      function new();
         compressed     = 1'b1;
         stride_reg     = 3'd4;
         total_reg      = 25'd1;
         mismatch_count = 0;
         restart();
      endfunction

      function void restart();
         awaiting_header = 1'b1;
         packet_is_run   = 1'b0;
         packet_left     = '0;
         run_len         = '0;
         byte_pos        = '0;
         assembly        = '0;
         done_count      = '0;
      endfunction

      function void write_reg(tgarle_pkg::reg_index_type idx, logic [31:0] value);
         case (idx)
            tgarle_pkg::REG_COMPRESSED_MODE: compressed = value[0];
            tgarle_pkg::REG_PIXEL_STRIDE:    stride_reg = value[2:0];
            tgarle_pkg::REG_TOTAL_PIXELS:    total_reg  = value[24:0];
            default: ;
         endcase
      endfunction

      function int stride();
         return (stride_reg >= 3'd4) ? 4 : 3;
      endfunction

      // zero acts as one, anything past 2^24 is clamped
      function int image_size();
         if (total_reg == 0) return 1;
         if (total_reg > 25'h100_0000) return 32'h100_0000;
         return int'(total_reg);
      endfunction

      function void note_input(logic [7:0] data, logic stream_end);
         logic [25:0]    total;
         logic [25:0]    reach;
         logic [7:0]     cnt;
         logic [7:0]     rep;
         pixel_item_type px;
         total = 26'(image_size());
         px    = '0;
         if (stream_end) begin
            // nothing of the image has arrived: the end is simply dropped
            if (done_count == 0 && byte_pos == 0 && (!compressed || awaiting_header))
               return;
            restart();
            px.error_code = tgarle_pkg::ERR_EARLY_END;
            pending_pixels.push_back(px);
            return;
         end
         if (compressed && awaiting_header) begin
            cnt   = {1'b0, data[6:0]} + 8'd1;
            reach = {1'b0, done_count} + 26'(cnt);
            if (reach > total) begin
               restart();
               px.error_code = tgarle_pkg::ERR_OVERRUN;
               pending_pixels.push_back(px);
               return;
            end
            awaiting_header = 1'b0;
            packet_is_run   = data[7];
            packet_left     = cnt;
            run_len         = cnt;
            byte_pos        = '0;
            assembly        = '0;
            return;
         end
         if (int'(byte_pos) + 1 < stride()) begin
            assembly = 24'({8'h00, assembly} | (32'(data) << (int'(byte_pos) * 8)));
            byte_pos = byte_pos + 2'd1;
            return;
         end
         px.blue  = assembly[7:0];
         px.green = assembly[15:8];
         if (stride() == 4) begin
            px.red   = assembly[23:16];
            px.alpha = data;
         end else begin
            px.red   = data;
            px.alpha = 8'h00;
         end
         byte_pos = '0;
         assembly = '0;
         if (compressed) begin
            rep = packet_is_run ? run_len : 8'd1;
            if (rep == 0) rep = 8'd1;
            if (rep >= packet_left) packet_left = '0;
            else packet_left = packet_left - rep;
            if (packet_left == 0) awaiting_header = 1'b1;
         end else begin
            rep = 8'd1;
         end
         done_count      = done_count + 25'(rep);
         px.repeat_count = rep;
         px.image_last   = ({1'b0, done_count} >= total);
         if (px.image_last) restart();
         pending_pixels.push_back(px);
      endfunction

      task report(string what);
         mismatch_count++;
         $display("mismatch: %s", what);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      task check_result(pixel_item_type got);
         pixel_item_type want;
         if (pending_pixels.size() == 0) begin
            report("rsp transfer with no pixel pending");
            return;
         end
         want = pending_pixels.pop_front();
         compare_field("blue", got.blue, want.blue);
         compare_field("green", got.green, want.green);
         compare_field("red", got.red, want.red);
         compare_field("alpha", got.alpha, want.alpha);
         compare_field("repeat_count", got.repeat_count, want.repeat_count);
         compare_field("image_last", 8'(got.image_last), 8'(want.image_last));
         compare_field("error_code", 8'(got.error_code), 8'(want.error_code));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // signals, every input known from time zero
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [7:0] data_byte
   logic [0:0]  req_tuser   = '0;   // [0] stream_end
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // [7:0] blue, [15:8] green, [23:16] red, [31:24] alpha, [39:32] repeat_count
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;          // image_last
   logic [1:0]  rsp_tuser;          // [1:0] error_code
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [tgarle_pkg::CSR_ADDR_BITS-1:0] csr_paddr  = '0;
   logic [tgarle_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [tgarle_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic        csr_pready;

   tga_pixel_predictor pixel_pred = new();
   bit          send_gaps   = 1'b1;   // sender idles now and then
   bit          rsp_stalls  = 1'b1;   // receiver drops tready now and then
   int          bytes_sent  = 0;
   int unsigned cycle_count = 0;

   tga_rle_pixel_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // rsp side: values read here are the ones from before the edge, so a
   // transfer is seen exactly when tvalid and tready were both high
   initial begin
      pixel_item_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.blue         = rsp_tdata[7:0];
            got.green        = rsp_tdata[15:8];
            got.red          = rsp_tdata[23:16];
            got.alpha        = rsp_tdata[31:24];
            got.repeat_count = rsp_tdata[39:32];
            got.image_last   = rsp_tlast;
            got.error_code   = tgarle_pkg::err_type'(rsp_tuser);
            pixel_pred.check_result(got);
         end
         rsp_tready <= rsp_stalls ? ($urandom_range(0, 99) >= 25) : 1'b1;
      end
   end

   // one byte or stream end on req; tvalid stays high into the next call
   task automatic send_item(input logic [7:0] data, input logic stream_end);
      if (send_gaps && $urandom_range(0, 99) < 17) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= stream_end;
      do @(posedge clock); while (!req_tready);
      pixel_pred.note_input(data, stream_end);
      bytes_sent++;
   endtask

   // sender holds off until every predicted transfer has come out, then
   // waits on for a byte that is still in flight without a result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pixel_pred.pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input tgarle_pkg::reg_index_type idx,
                            input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      pixel_pred.write_reg(idx, value);
   endtask

   // well-formed image with random content; with breaks set it may end in an
   // overrunning header or a stream end in the middle of a pixel.
   // images larger than cap are cut short by a stream end
   task automatic send_image(input int cap, input bit breaks);
      int  left;
      int  lim;
      int  c;
      int  npix;
      int  cut;
      int  pb;
      bit  run;
      bit  truncated;
      pb        = pixel_pred.stride();
      truncated = pixel_pred.image_size() > cap;
      left      = truncated ? cap : pixel_pred.image_size();
      while (left > 0) begin
         if (pixel_pred.compressed) begin
            // header asking for more pixels than the image has left
            if (breaks && !truncated && left < 128 && $urandom_range(0, 99) < 4) begin
               send_item({1'($urandom), 7'($urandom_range(left, 127))}, 1'b0);
               return;
            end
            lim  = (left < 128) ? left : 128;
            c    = ($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, lim);
            run  = $urandom_range(0, 1);
            send_item({run, 7'(c - 1)}, 1'b0);
            npix = run ? 1 : c;
         end else begin
            c    = 1;
            npix = 1;
         end
         repeat (npix) begin
            cut = (breaks && $urandom_range(0, 99) < 2) ? $urandom_range(0, pb - 1) : pb;
            repeat (cut) send_item(8'($urandom), 1'b0);
            if (cut < pb) begin
               send_item(8'($urandom), 1'b1);
               return;
            end
         end
         left -= c;
      end
      if (truncated) send_item(8'($urandom), 1'b1);
   endtask

   initial begin
      int          phase;
      logic [31:0] total;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed, reset settings: rle, 4-byte pixels, one-pixel images
      send_item(8'h00, 1'b1);                      // end between images
      send_item(8'h00, 1'b0);                      // raw packet of one
      repeat (4) send_item(8'hff, 1'b0);
      send_item(8'h81, 1'b0);                      // run of two overruns
      send_item(8'hff, 1'b0);                      // run of 128 overruns
      send_item(8'h00, 1'b0);
      send_item(8'h12, 1'b0);
      send_item(8'h34, 1'b0);
      send_item(8'h00, 1'b1);                      // end inside a pixel
      wait_drained();

      // total of zero acts as one, 3-byte pixels
      csr_write(tgarle_pkg::REG_TOTAL_PIXELS, 32'd0);
      csr_write(tgarle_pkg::REG_PIXEL_STRIDE, 32'd3);
      send_item(8'h80, 1'b0);
      send_item(8'hab, 1'b0);
      send_item(8'hcd, 1'b0);
      send_item(8'hef, 1'b0);
      wait_drained();

      // longest run, then a run that passes the end of the image
      csr_write(tgarle_pkg::REG_TOTAL_PIXELS, 32'd150);
      send_item(8'hff, 1'b0);
      repeat (3) send_item(8'($urandom), 1'b0);
      send_item(8'h96, 1'b0);
      wait_drained();

      // registers changed while an image is under way
      csr_write(tgarle_pkg::REG_TOTAL_PIXELS, 32'd10);
      csr_write(tgarle_pkg::REG_PIXEL_STRIDE, 32'd4);
      send_item(8'h84, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'h02, 1'b0);
      wait_drained();
      csr_write(tgarle_pkg::REG_PIXEL_STRIDE, 32'd3);   // pixel now completes early
      send_item(8'h03, 1'b0);
      wait_drained();
      csr_write(tgarle_pkg::REG_COMPRESSED_MODE, 32'd0);
      csr_write(tgarle_pkg::REG_TOTAL_PIXELS, 32'd6);
      repeat (3) send_item(8'($urandom), 1'b0);    // raw pixel closes the image
      wait_drained();

      // random phases, each with its own settings; phase 2 runs with no idling
      for (phase = 0; phase < 3 || bytes_sent < RANDOM_BYTES; phase++) begin
         send_gaps  = (phase != 2);
         rsp_stalls = (phase != 2);
         csr_write(tgarle_pkg::REG_COMPRESSED_MODE, 32'($urandom_range(0, 3) != 0));
         csr_write(tgarle_pkg::REG_PIXEL_STRIDE, ($urandom_range(0, 4) == 0) ?
                   32'($urandom_range(0, 7)) : 32'($urandom_range(3, 4)));
         case ($urandom_range(0, 19)) inside
            0:       total = 32'd0;
            1:       total = 32'h0100_0000;
            2:       total = 32'h01ff_ffff;
            [3:4]:   total = $urandom_range(25, 300);
            default: total = $urandom_range(1, 24);
         endcase
         csr_write(tgarle_pkg::REG_TOTAL_PIXELS, total);
         send_item(8'($urandom), 1'b1);            // closes whatever image is open
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise, then a stream end to get back to a fresh image
               repeat ($urandom_range(1, 6))
                  send_item(8'($urandom), 1'($urandom_range(0, 4) == 0));
               send_item(8'($urandom), 1'b1);
            end
            send_image(40, 1'b1);
         end
         wait_drained();
      end
      send_gaps  = 1'b1;
      rsp_stalls = 1'b1;
      repeat (10) @(posedge clock);

      if (pixel_pred.pending_pixels.size() != 0)
         pixel_pred.report("predicted transfers never arrived");
      if (pixel_pred.mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
